@@ hdl/weighted_log_return_correlation_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the weighted log-return correlation block
// ---------------------------------------------------------------------------
`ifndef WEIGHTED_LOG_RETURN_CORRELATION_MACROS_SVH
`define WEIGHTED_LOG_RETURN_CORRELATION_MACROS_SVH

// checked only outside reset
`define WLRC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define WLRC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/wlrc_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_pkg
// Beat types, codes and fixed constants of the weighted correlation block.
// ---------------------------------------------------------------------------
package wlrc_pkg;

  typedef struct packed {
    logic [31:0] price_a;
    logic [31:0] price_b;
    logic        last_day;
  } in_beat_t;

  typedef struct packed {
    logic signed [31:0] correlation;
    logic [1:0]         status;
  } out_beat_t;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_FEW_DAYS   = 2'd1,
    STAT_ZERO_PRICE = 2'd2,
    STAT_ZERO_VAR   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOG, ST_RET, ST_UPD, ST_FIN, ST_MEAN, ST_PR, ST_PD,
    ST_PM, ST_PW, ST_PA, ST_CHK, ST_SQRT, ST_DEN, ST_DIV, ST_OUT
  } state_t;

  localparam logic [15:0] DECAY_RESET = 16'd61604;
  localparam logic [31:0] WEIGHT_ONE  = 32'h8000_0000;
  localparam logic [30:0] LN2_Q31     = 31'd1488522236;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [39:0] WTOTAL_MAX  = 40'hFF_FFFF_FFFF;
  localparam int          LOG_FRAC    = 26;
  localparam int          MOM_SHIFT   = 12;
  // 64 integer quotient bits plus the Q1.30 fraction
  localparam int          DIV_BASE    = 94;

endpackage

@@ hdl/weighted_log_return_correlation.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_log_return_correlation
// EWMA-weighted correlation of the log returns of two price series.
// ---------------------------------------------------------------------------
//  port group | dir | beat             | handshake
//  in_        | in  | in_beat_t        | in_valid / in_stall
//  out_       | out | out_beat_t       | out_valid / out_stall
//  cfg_       | in  | decay, Q0.16     | cfg_we, no wait
//
// A day runs the 26-step log2 squaring loop, then the return multiply and
// the store write. Closing a window runs the mean division, then for each
// stored return the RAM read, products and weighting, then the root, then
// the quotient bits.
// Reset is synchronous and leaves the window empty; the return store needs
// no clearing. The result waits in an output register; the next window's
// days are taken meanwhile, only the next result waits for it.
// ---------------------------------------------------------------------------
module weighted_log_return_correlation import wlrc_pkg::*; #(
  parameter int MAX_DAYS = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int CW    = $clog2(MAX_DAYS + 1);
  localparam int AW    = $clog2(MAX_DAYS);
  localparam int DEPTH = MAX_DAYS - 1;
  localparam logic [CW-1:0] DAYS_FULL = CW'(MAX_DAYS);
  localparam logic [CW-1:0] DAYS_MIN  = CW'(2);

  state_t state_r, state_nxt;

  logic        log_start, mdiv_start, sqrt_start, ram_we;
  logic        log_busy_a, log_busy_b, mdiv_busy_a, mdiv_busy_b;
  logic        sqrt_busy_a, sqrt_busy_b;
  logic [31:0] log_a, log_b;
  logic [47:0] mq_a, mq_b;
  logic [31:0] root_a, root_b;
  logic signed [5:0] exp_a, exp_b;
  logic [63:0] ram_rdata;
  logic [63:0] ram_wdata;

  logic [15:0] decay_r;
  logic [31:0] pa_r, pb_r;
  logic        last_r;
  logic [CW-1:0] day_r;
  logic        err_r;
  logic        prev_nz_r;
  logic [31:0] lpa_r, lpb_r;
  logic signed [47:0] sum_a_r, sum_b_r;
  logic [31:0] cw_r;
  logic [39:0] wt_r;

  logic        ok_r, nega_r, negb_r;
  logic [63:0] proda_r, prodb_r;

  logic [31:0] mean_a_r, mean_b_r;
  logic [CW-1:0] idx_r, nret_r;
  logic [31:0] w_r;
  logic [31:0] ma_r, mb_r;
  logic        sdiff_r;
  logic [63:0] paa_r, pbb_r, pab_r;
  logic [63:0] hi_aa_r, lo_aa_r, hi_bb_r, lo_bb_r, hi_ab_r, lo_ab_r;
  logic [63:0] acc0_r, acc1_r, acc2_r;

  logic [63:0] den_r, fd_rem_r, fd_dvd_r;
  logic        cneg_r, fd_sat_r;
  logic [30:0] fd_q_r;
  logic [7:0]  fd_cnt_r;
  logic [31:0] res_corr_r;
  status_t     res_stat_r;
  logic        out_valid_r;
  out_beat_t   out_data_r;

  // combinational datapath terms
  logic [31:0] mag_a, mag_b, ra, rb;
  logic [32:0] da, db, mda, mdb;
  logic [63:0] t_aa, t_bb, t_ab;
  logic [40:0] wt_sum;
  logic [47:0] cw_prod, w_prod;
  logic [63:0] rem_sh, rem_sub;
  logic        fd_ge;
  logic [31:0] qn, q_fin;

  // ---- units ----
  wlrc_log2 u_log_a (.clk, .rst_n, .start(log_start), .price(in_data.price_a),
                     .busy(log_busy_a), .log_q26(log_a));
  wlrc_log2 u_log_b (.clk, .rst_n, .start(log_start), .price(in_data.price_b),
                     .busy(log_busy_b), .log_q26(log_b));

  wlrc_sdiv #(.W(48), .DW(CW)) u_mdiv_a (
    .clk, .rst_n, .start(mdiv_start),
    .dividend(sum_a_r[47] ? 48'(-sum_a_r) : 48'(sum_a_r)),
    .divisor(day_r - 1'b1), .busy(mdiv_busy_a), .quotient(mq_a));
  wlrc_sdiv #(.W(48), .DW(CW)) u_mdiv_b (
    .clk, .rst_n, .start(mdiv_start),
    .dividend(sum_b_r[47] ? 48'(-sum_b_r) : 48'(sum_b_r)),
    .divisor(day_r - 1'b1), .busy(mdiv_busy_b), .quotient(mq_b));

  wlrc_sqrt u_sqrt_a (.clk, .rst_n, .start(sqrt_start), .value(acc0_r),
                      .busy(sqrt_busy_a), .root(root_a), .shift_exp(exp_a));
  wlrc_sqrt u_sqrt_b (.clk, .rst_n, .start(sqrt_start), .value(acc1_r),
                      .busy(sqrt_busy_b), .root(root_b), .shift_exp(exp_b));

  wlrc_ram #(.WIDTH(64), .DEPTH(DEPTH), .AW(AW)) u_store (
    .clk, .we(ram_we), .waddr(AW'(day_r - 1'b1)), .wdata(ram_wdata),
    .raddr(idx_r[AW-1:0]), .rdata(ram_rdata));

  // ---- load-side arithmetic ----
  assign mag_a = (log_a > lpa_r) ? (log_a - lpa_r) : (lpa_r - log_a);
  assign mag_b = (log_b > lpb_r) ? (log_b - lpb_r) : (lpb_r - log_b);
  assign ra = !ok_r ? 32'd0 : (nega_r ? (~proda_r[62:31] + 32'd1) : proda_r[62:31]);
  assign rb = !ok_r ? 32'd0 : (negb_r ? (~prodb_r[62:31] + 32'd1) : prodb_r[62:31]);
  assign ram_wdata = {rb, ra};
  assign wt_sum  = {1'b0, wt_r} + {9'd0, cw_r};
  assign cw_prod = {16'd0, cw_r} * {32'd0, decay_r};
  assign w_prod  = {16'd0, w_r} * {32'd0, decay_r};

  // ---- pass arithmetic ----
  assign da  = {ram_rdata[31], ram_rdata[31:0]} - {mean_a_r[31], mean_a_r};
  assign db  = {ram_rdata[63], ram_rdata[63:32]} - {mean_b_r[31], mean_b_r};
  assign mda = da[32] ? (~da + 33'd1) : da;
  assign mdb = db[32] ? (~db + 33'd1) : db;
  assign t_aa = (hi_aa_r + {32'd0, lo_aa_r[63:32]}) >> MOM_SHIFT;
  assign t_bb = (hi_bb_r + {32'd0, lo_bb_r[63:32]}) >> MOM_SHIFT;
  assign t_ab = (hi_ab_r + {32'd0, lo_ab_r[63:32]}) >> MOM_SHIFT;

  // ---- final long division ----
  assign rem_sh  = {fd_rem_r[62:0], fd_dvd_r[63]};
  assign fd_ge   = rem_sh >= den_r;
  assign rem_sub = rem_sh - den_r;
  assign qn      = {fd_q_r, fd_ge};
  assign q_fin   = fd_sat_r ? {1'b0, ONE_Q30} : {1'b0, fd_q_r};

  // ---- control ----
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    log_start  = 1'b0;
    mdiv_start = 1'b0;
    sqrt_start = 1'b0;
    ram_we     = 1'b0;
    in_stall   = 1'b1;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (day_r < DAYS_FULL) begin
            log_start = 1'b1;
            state_nxt = ST_LOG;
          end else if (in_data.last_day) begin
            state_nxt = ST_FIN;
          end
        end
      end
      ST_LOG: if (!log_busy_a && !log_busy_b) state_nxt = ST_RET;
      ST_RET: state_nxt = ST_UPD;
      ST_UPD: begin
        ram_we    = day_r != '0;
        state_nxt = last_r ? ST_FIN : ST_IDLE;
      end
      ST_FIN: begin
        if (day_r < DAYS_MIN || err_r) begin
          state_nxt = ST_OUT;
        end else begin
          mdiv_start = 1'b1;
          state_nxt  = ST_MEAN;
        end
      end
      ST_MEAN: if (!mdiv_busy_a && !mdiv_busy_b) state_nxt = ST_PR;
      ST_PR:   state_nxt = ST_PD;
      ST_PD:   state_nxt = ST_PM;
      ST_PM:   state_nxt = ST_PW;
      ST_PW:   state_nxt = ST_PA;
      ST_PA:   state_nxt = (idx_r + 1'b1 == nret_r) ? ST_CHK : ST_PR;
      ST_CHK: begin
        if (acc0_r == '0 || acc1_r == '0) begin
          state_nxt = ST_OUT;
        end else begin
          sqrt_start = 1'b1;
          state_nxt  = ST_SQRT;
        end
      end
      ST_SQRT: if (!sqrt_busy_a && !sqrt_busy_b) state_nxt = ST_DEN;
      ST_DEN:  state_nxt = ST_DIV;
      ST_DIV:  if (fd_cnt_r == 8'd0) state_nxt = ST_OUT;
      ST_OUT:  if (!out_valid_r) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      decay_r     <= DECAY_RESET;
      day_r       <= '0;
      err_r       <= 1'b0;
      prev_nz_r   <= 1'b0;
      sum_a_r     <= '0;
      sum_b_r     <= '0;
      cw_r        <= WEIGHT_ONE;
      wt_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) decay_r <= cfg_wdata;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          pa_r   <= in_data.price_a;
          pb_r   <= in_data.price_b;
          last_r <= in_data.last_day;
        end
        ST_RET: begin
          ok_r    <= (day_r != '0) && (pa_r != '0) && (pb_r != '0) && prev_nz_r;
          nega_r  <= log_a > lpa_r;
          negb_r  <= log_b > lpb_r;
          proda_r <= {32'd0, mag_a} * {33'd0, LN2_Q31} + 64'h4000_0000;
          prodb_r <= {32'd0, mag_b} * {33'd0, LN2_Q31} + 64'h4000_0000;
        end
        ST_UPD: begin
          if (day_r != '0) begin
            sum_a_r <= sum_a_r + {{16{ra[31]}}, ra};
            sum_b_r <= sum_b_r + {{16{rb[31]}}, rb};
            wt_r    <= (wt_sum > {1'b0, WTOTAL_MAX}) ? WTOTAL_MAX : wt_sum[39:0];
            cw_r    <= cw_prod[47:16];
          end
          if (pa_r == '0 || pb_r == '0) err_r <= 1'b1;
          prev_nz_r <= (pa_r != '0) && (pb_r != '0);
          lpa_r     <= log_a;
          lpb_r     <= log_b;
          day_r     <= day_r + 1'b1;
        end
        ST_FIN: begin
          res_corr_r <= '0;
          res_stat_r <= (day_r < DAYS_MIN) ? STAT_FEW_DAYS : STAT_ZERO_PRICE;
          nret_r     <= day_r - 1'b1;
        end
        ST_MEAN: begin
          mean_a_r <= sum_a_r[47] ? (~mq_a[31:0] + 32'd1) : mq_a[31:0];
          mean_b_r <= sum_b_r[47] ? (~mq_b[31:0] + 32'd1) : mq_b[31:0];
          idx_r    <= '0;
          w_r      <= WEIGHT_ONE;
          acc0_r   <= '0;
          acc1_r   <= '0;
          acc2_r   <= '0;
        end
        ST_PD: begin
          ma_r    <= mda[31:0];
          mb_r    <= mdb[31:0];
          sdiff_r <= da[32] ^ db[32];
        end
        ST_PM: begin
          paa_r <= {32'd0, ma_r} * {32'd0, ma_r};
          pbb_r <= {32'd0, mb_r} * {32'd0, mb_r};
          pab_r <= {32'd0, ma_r} * {32'd0, mb_r};
        end
        ST_PW: begin
          hi_aa_r <= {32'd0, paa_r[63:32]} * {32'd0, w_r};
          lo_aa_r <= {32'd0, paa_r[31:0]} * {32'd0, w_r};
          hi_bb_r <= {32'd0, pbb_r[63:32]} * {32'd0, w_r};
          lo_bb_r <= {32'd0, pbb_r[31:0]} * {32'd0, w_r};
          hi_ab_r <= {32'd0, pab_r[63:32]} * {32'd0, w_r};
          lo_ab_r <= {32'd0, pab_r[31:0]} * {32'd0, w_r};
        end
        ST_PA: begin
          acc0_r <= acc0_r + t_aa;
          acc1_r <= acc1_r + t_bb;
          acc2_r <= sdiff_r ? (acc2_r - t_ab) : (acc2_r + t_ab);
          w_r    <= w_prod[47:16];
          idx_r  <= idx_r + 1'b1;
        end
        ST_CHK: begin
          res_corr_r <= '0;
          res_stat_r <= STAT_ZERO_VAR;
        end
        ST_DEN: begin
          den_r    <= {32'd0, root_a} * {32'd0, root_b};
          cneg_r   <= acc2_r[63];
          fd_dvd_r <= acc2_r[63] ? (~acc2_r + 64'd1) : acc2_r;
          fd_rem_r <= '0;
          fd_q_r   <= '0;
          fd_sat_r <= 1'b0;
          fd_cnt_r <= 8'(DIV_BASE + int'(exp_a) + int'(exp_b));
        end
        ST_DIV: begin
          if (fd_cnt_r != 8'd0) begin
            // dividend bits run out into zeros after 64 steps
            fd_dvd_r <= {fd_dvd_r[62:0], 1'b0};
            fd_rem_r <= fd_ge ? rem_sub : rem_sh;
            if (fd_sat_r || qn > {1'b0, ONE_Q30}) fd_sat_r <= 1'b1;
            else fd_q_r <= qn[30:0];
            fd_cnt_r <= fd_cnt_r - 8'd1;
          end else begin
            res_corr_r <= cneg_r ? (~q_fin + 32'd1) : q_fin;
            res_stat_r <= STAT_OK;
          end
        end
        ST_OUT: begin
          if (!out_valid_r) begin
            out_valid_r            <= 1'b1;
            out_data_r.correlation <= res_corr_r;
            out_data_r.status      <= res_stat_r;
            day_r     <= '0;
            err_r     <= 1'b0;
            prev_nz_r <= 1'b0;
            sum_a_r   <= '0;
            sum_b_r   <= '0;
            cw_r      <= WEIGHT_ONE;
            wt_r      <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

@@ hdl/wlrc_ram.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_ram
// Simple dual-port RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module wlrc_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 255,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem_r[waddr] <= wdata;
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/wlrc_log2.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_log2
// Iterative log2 of a Q16.16 price into unsigned Q5.26, one square a cycle.
// ---------------------------------------------------------------------------
module wlrc_log2 import wlrc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] price,
  output logic        busy,
  output logic [31:0] log_q26
);

  logic [31:0]         m_r;
  logic [LOG_FRAC-1:0] f_r;
  logic [4:0]          k_r;
  logic [4:0]          cnt_r;
  logic                busy_r;
  logic [4:0]          top_bit;
  logic [63:0]         sq;
  logic [32:0]         sq_sh;

  always_comb begin
    top_bit = '0;
    for (int i = 1; i < 32; i++) begin
      if (price[i]) top_bit = 5'(i);
    end
  end

  assign sq    = {32'd0, m_r} * {32'd0, m_r};
  assign sq_sh = sq[63:31];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (start) begin
      busy_r <= 1'b1;
      k_r    <= top_bit;
      m_r    <= price << (5'd31 - top_bit);
      f_r    <= '0;
      cnt_r  <= 5'(LOG_FRAC - 1);
    end else if (busy_r) begin
      // square at or above 2.0 gives a one bit and is halved
      f_r <= {f_r[LOG_FRAC-2:0], sq_sh[32]};
      m_r <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
      if (cnt_r == 5'd0) busy_r <= 1'b0;
      else cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy    = busy_r;
  assign log_q26 = {1'b0, k_r, f_r};

endmodule

@@ hdl/wlrc_sdiv.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_sdiv
// Restoring unsigned divider, one quotient bit a cycle.
// ---------------------------------------------------------------------------
module wlrc_sdiv #(
  parameter int W  = 48,
  parameter int DW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [W-1:0]  dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic [W-1:0]  quotient
);

  localparam int CNTW = $clog2(W + 1);

  logic [W-1:0]    q_r;
  logic [DW-1:0]   rem_r;
  logic [DW-1:0]   div_r;
  logic [CNTW-1:0] cnt_r;
  logic [DW:0]     rem_sh;
  logic [DW:0]     rem_sub;
  logic            ge;

  assign rem_sh  = {rem_r, q_r[W-1]};
  assign ge      = rem_sh >= {1'b0, div_r};
  assign rem_sub = rem_sh - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      div_r <= divisor;
      cnt_r <= CNTW'(W);
    end else if (cnt_r != '0) begin
      rem_r <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
      q_r   <= {q_r[W-2:0], ge};
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = q_r;

endmodule

@@ hdl/wlrc_sqrt.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_sqrt
// Normalises a 64-bit variance by even shifts, then takes its integer root
// two bits a cycle.
// ---------------------------------------------------------------------------
module wlrc_sqrt (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       value,
  output logic              busy,
  output logic [31:0]       root,
  output logic signed [5:0] shift_exp
);

  logic [63:0]       x_r;
  logic [63:0]       r_r;
  logic [63:0]       bit_r;
  logic signed [5:0] exp_r;
  logic              norm_r;
  logic              run_r;
  logic [63:0]       trial;

  assign trial = r_r + bit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      norm_r <= 1'b0;
      run_r  <= 1'b0;
    end else if (start) begin
      r_r   <= '0;
      bit_r <= 64'd1 << 62;
      if (value[63:62] != 2'b00) begin
        x_r    <= value >> 2;
        exp_r  <= -6'sd1;
        run_r  <= 1'b1;
      end else begin
        x_r    <= value;
        exp_r  <= 6'sd0;
        norm_r <= 1'b1;
      end
    end else if (norm_r) begin
      if (x_r[61:60] != 2'b00) begin
        norm_r <= 1'b0;
        run_r  <= 1'b1;
      end else begin
        x_r   <= x_r << 2;
        exp_r <= exp_r + 6'sd1;
      end
    end else if (run_r) begin
      if (x_r >= trial) begin
        x_r <= x_r - trial;
        r_r <= (r_r >> 1) + bit_r;
      end else begin
        r_r <= r_r >> 1;
      end
      bit_r <= bit_r >> 2;
      if (bit_r[0]) run_r <= 1'b0;
    end
  end

  assign busy      = norm_r | run_r;
  assign root      = r_r[31:0];
  assign shift_exp = exp_r;

endmodule

@@ hdl/wlrc_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// wlrc_checker
// Port-level checks on the correlation block, bound to the top level.
// ---------------------------------------------------------------------------
`include "weighted_log_return_correlation_macros.svh"

module wlrc_checker import wlrc_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  `WLRC_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled result beat changed")
  `WLRC_ASSERT(a_err_zero, out_valid && out_data.status != STAT_OK |-> out_data.correlation == 32'sd0, "error result with nonzero correlation")
  `WLRC_ASSERT(a_corr_range, out_valid |-> out_data.correlation <= 32'sh4000_0000 && out_data.correlation >= -32'sh4000_0000, "correlation beyond plus or minus one")
  `WLRC_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_valid && !in_stall, "block not idle after reset")

endmodule

bind weighted_log_return_correlation wlrc_checker u_wlrc_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_stall (in_stall),
  .out_valid(out_valid),
  .out_stall(out_stall),
  .out_data (out_data)
);

@@ sim/weighted_log_return_correlation_test.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// weighted_log_return_correlation_test
// Drives windows of daily price pairs (random walks, flat, noisy, zero-price,
// overlong) through the block under several decay settings and idle/stall
// patterns, and checks each correlation result against a bit-exact predictor.
// ---------------------------------------------------------------------------
module weighted_log_return_correlation_test;
  import wlrc_pkg::*;

  localparam int DAYS = 256;

  typedef enum int {WIN_WALK, WIN_FLAT, WIN_NOISE, WIN_ZERO} win_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [15:0] cfg_wdata = '0;

  in_beat_t  day_queue[$];
  out_beat_t corr_expected[$];
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  bit        hold_phase = 1'b0;
  bit        held = 1'b0;
  int        hold_cycles = 0;
  int        mismatches = 0;

  // predictor state
  logic [15:0] decay;
  logic [31:0] ret_a[DAYS-1];
  logic [31:0] ret_b[DAYS-1];
  logic [31:0] prev_a, prev_b;
  int          days;
  longint      sum_a, sum_b;
  logic [31:0] weight;
  bit          zero_seen;

  weighted_log_return_correlation DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  initial begin
    #40ms;
    $display("weighted_log_return_correlation_test failed");
    $finish;
  end

  function automatic logic [31:0] log2_fix(logic [31:0] p);
    int k;
    logic [63:0] m;
    logic [31:0] f;
    k = 31;
    f = '0;
    while (k > 0 && !p[k]) k--;
    m = {32'd0, p} << (31 - k);
    for (int i = 0; i < 26; i++) begin
      m = (m * m) >> 31;
      f = f << 1;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        f[0] = 1'b1;
      end
    end
    return (32'(k) << 26) | f;
  endfunction

  function automatic logic [31:0] log_ret(logic [31:0] prev, logic [31:0] cur);
    logic [31:0] lp, lc;
    logic [63:0] mag, r;
    bit neg;
    lp = log2_fix(prev);
    lc = log2_fix(cur);
    neg = lc > lp;
    mag = neg ? 64'(lc - lp) : 64'(lp - lc);
    r = (mag * 64'(LN2_Q31) + 64'h4000_0000) >> 31;
    return neg ? 32'(0) - r[31:0] : r[31:0];
  endfunction

  function automatic logic [63:0] weigh(logic [63:0] p, logic [31:0] w);
    logic [63:0] hi, lo;
    hi = (p >> 32) * 64'(w);
    lo = ((p & 64'hFFFF_FFFF) * 64'(w)) >> 32;
    return (hi + lo) >> 12;
  endfunction

  function automatic logic [63:0] isqrt(logic [63:0] v);
    logic [63:0] r, b;
    r = '0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] norm_root(logic [63:0] v, output int sc);
    int m, s;
    m = 63;
    while (m > 0 && !v[m]) m--;
    if (m >= 62) begin
      sc = -1;
      return isqrt(v >> 2);
    end
    s = (61 - m) & ~1;
    sc = s / 2;
    return isqrt(v << s);
  endfunction

  function automatic void clear_window();
    prev_a = '0;
    prev_b = '0;
    days = 0;
    sum_a = 0;
    sum_b = 0;
    weight = WEIGHT_ONE;
    zero_seen = 1'b0;
  endfunction

  function automatic out_beat_t close_window();
    out_beat_t res;
    int n, ea, eb, e, k;
    longint mean_a, mean_b, da, db;
    logic [63:0] ma, mb, t, va, vb, cv, ncov, sa, sb, den, q, r;
    logic [31:0] w;
    bit neg;
    res = '0;
    va = '0;
    vb = '0;
    cv = '0;
    w = WEIGHT_ONE;
    if (days < 2) begin
      res.status = STAT_FEW_DAYS;
      return res;
    end
    if (zero_seen) begin
      res.status = STAT_ZERO_PRICE;
      return res;
    end
    n = days - 1;
    mean_a = sum_a / longint'(n);
    mean_b = sum_b / longint'(n);
    for (int i = 0; i < n && i < DAYS - 1; i++) begin
      da = longint'(signed'(ret_a[i])) - mean_a;
      db = longint'(signed'(ret_b[i])) - mean_b;
      ma = da < 0 ? 64'(-da) : 64'(da);
      mb = db < 0 ? 64'(-db) : 64'(db);
      t = weigh(ma * mb, w);
      va += weigh(ma * ma, w);
      vb += weigh(mb * mb, w);
      if ((da < 0) != (db < 0)) cv -= t;
      else cv += t;
      w = 32'((64'(w) * 64'(decay)) >> 16);
    end
    if (va == 0 || vb == 0) begin
      res.status = STAT_ZERO_VAR;
      return res;
    end
    res.status = STAT_OK;
    sa = norm_root(va, ea);
    sb = norm_root(vb, eb);
    den = sa * sb;
    neg = cv[63];
    ncov = neg ? 64'd0 - cv : cv;
    e = 30 + ea + eb;
    q = ncov / den;
    r = ncov % den;
    for (k = 0; k < e && q <= 64'(ONE_Q30); k++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    if (q > 64'(ONE_Q30)) q = 64'(ONE_Q30);
    res.correlation = neg ? 32'(0) - q[31:0] : q[31:0];
    return res;
  endfunction

  // advance the window by one day unless it is full; returns 1 when a result is due
  function automatic bit take_day(in_beat_t d, output out_beat_t res);
    logic [31:0] ra, rb;
    res = '0;
    if (days < DAYS) begin
      if (d.price_a == 0 || d.price_b == 0) zero_seen = 1'b1;
      if (days >= 1) begin
        ra = '0;
        rb = '0;
        if (d.price_a != 0 && d.price_b != 0 && prev_a != 0 && prev_b != 0) begin
          ra = log_ret(prev_a, d.price_a);
          rb = log_ret(prev_b, d.price_b);
        end
        if (days - 1 < DAYS - 1) begin
          ret_a[days-1] = ra;
          ret_b[days-1] = rb;
        end
        sum_a += longint'(signed'(ra));
        sum_b += longint'(signed'(rb));
        weight = 32'((64'(weight) * 64'(decay)) >> 16);
      end
      prev_a = d.price_a;
      prev_b = d.price_b;
      days++;
    end
    if (!d.last_day) return 1'b0;
    res = close_window();
    clear_window();
    return 1'b1;
  endfunction

  always @(posedge clk) begin : drive_days
    out_beat_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        if (take_day(in_data, res)) corr_expected.push_back(res);
      end
      if (!in_valid || !in_stall) begin
        if (day_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= day_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : watch_results
    out_beat_t exp_beat;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (corr_expected.size() == 0) begin
          $error("unexpected result beat: correlation %0d status %0d",
                 out_data.correlation, out_data.status);
          mismatches++;
        end else begin
          exp_beat = corr_expected.pop_front();
          if (out_data.correlation !== exp_beat.correlation) begin
            $error("correlation: expected %0d, got %0d",
                   exp_beat.correlation, out_data.correlation);
            mismatches++;
          end
          if (out_data.status !== exp_beat.status) begin
            $error("status: expected %0d, got %0d", exp_beat.status, out_data.status);
            mismatches++;
          end
        end
      end
    end
  end

  // long hold-off so the output register fills and the input backs up
  always @(posedge clk) begin : stall_results
    if (rst_n) begin
      if (hold_phase && !held) begin
        held <= 1'b1;
        hold_cycles <= 3000;
        out_stall <= 1'b1;
      end else if (hold_cycles > 0) begin
        hold_cycles <= hold_cycles - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= $urandom_range(99) < recv_stall_pct;
      end
    end
  end

  function automatic void push_day(logic [31:0] a, logic [31:0] b, bit last);
    in_beat_t d;
    d.price_a = a;
    d.price_b = b;
    d.last_day = last;
    day_queue.push_back(d);
  endfunction

  function automatic logic [31:0] walk(logic [31:0] p);
    logic [31:0] step;
    step = ($urandom_range(3) == 0) ? $urandom() >> $urandom_range(31) : p >> $urandom_range(4, 9);
    if ($urandom_range(1)) p = p + step;
    else if (p > step) p = p - step;
    return (p == 0) ? 32'd1 : p;
  endfunction

  function automatic void add_window(int n, win_kind_t kind);
    logic [31:0] a, b;
    int zero_at;
    a = $urandom() >> $urandom_range(31);
    b = $urandom() >> $urandom_range(31);
    if (a == 0) a = 1;
    if (b == 0) b = 1;
    zero_at = $urandom_range(n - 1);
    for (int i = 0; i < n; i++) begin
      case (kind)
        WIN_WALK, WIN_ZERO: begin
          a = walk(a);
          b = ($urandom_range(1)) ? walk(b) : b + (a >> 8);
        end
        WIN_NOISE: begin
          a = $urandom();
          b = $urandom();
        end
        default: ;
      endcase
      if (kind == WIN_ZERO && i == zero_at) begin
        case ($urandom_range(2))
          0: push_day(32'd0, b, i == n - 1);
          1: push_day(a, 32'd0, i == n - 1);
          default: push_day(32'd0, 32'd0, i == n - 1);
        endcase
      end else begin
        push_day(a, b, i == n - 1);
      end
    end
  endfunction

  task automatic set_decay(logic [15:0] v);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    decay = v;
  endtask

  task automatic drain();
    while (day_queue.size() > 0 || in_valid || corr_expected.size() > 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task automatic random_phase(int items, bit overlong);
    int r;
    if (overlong) add_window(DAYS + 2, WIN_WALK);
    while (day_queue.size() < items) begin
      r = $urandom_range(99);
      if (r < 65) add_window($urandom_range(2, 24), WIN_WALK);
      else if (r < 75) add_window($urandom_range(2, 8), WIN_NOISE);
      else if (r < 83) add_window($urandom_range(2, 10), WIN_ZERO);
      else if (r < 90) add_window($urandom_range(2, 6), WIN_FLAT);
      else if (r < 95) add_window(1, WIN_NOISE);
      else add_window($urandom_range(30, 90), WIN_WALK);
    end
  endtask

  initial begin
    decay = DECAY_RESET;
    clear_window();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: single day, extreme prices, flat, zero prices, noise, walk
    push_day(32'h0001_0000, 32'h0001_0000, 1'b1);
    push_day(32'd1, 32'hFFFF_FFFF, 1'b0);
    push_day(32'hFFFF_FFFF, 32'd1, 1'b0);
    push_day(32'd1, 32'hFFFF_FFFF, 1'b0);
    push_day(32'hFFFF_FFFE, 32'd3, 1'b1);
    add_window(4, WIN_FLAT);
    push_day(32'd0, 32'h0002_0000, 1'b0);
    push_day(32'h0003_0000, 32'h0002_0000, 1'b1);
    push_day(32'h0003_0000, 32'h0002_0000, 1'b0);
    push_day(32'h0003_0000, 32'd0, 1'b1);
    push_day(32'h0010_0000, 32'h0020_0000, 1'b0);
    push_day(32'h0010_0000, 32'h0040_0000, 1'b1);
    add_window(5, WIN_NOISE);
    add_window(5, WIN_WALK);
    drain();

    set_decay(16'd0);
    random_phase(200, 1'b0);
    drain();

    set_decay(16'hFFFF);
    send_idle_pct = 67;
    random_phase(400, 1'b1);
    drain();

    set_decay(DECAY_RESET);
    send_idle_pct = 0;
    recv_stall_pct = 67;
    random_phase(400, 1'b0);
    drain();

    set_decay(16'($urandom()));
    send_idle_pct = 29;
    recv_stall_pct = 29;
    random_phase(400, 1'b0);
    drain();

    set_decay(16'($urandom_range(50000, 65535)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_phase = 1'b1;
    random_phase(300, 1'b0);
    drain();

    set_decay(16'd1);
    send_idle_pct = $urandom_range(10, 50);
    recv_stall_pct = $urandom_range(10, 50);
    random_phase(200, 1'b0);
    drain();

    if (mismatches == 0 && corr_expected.size() == 0) begin
      $display("weighted_log_return_correlation_test passed");
    end else begin
      $display("weighted_log_return_correlation_test failed");
    end
    $finish;
  end

endmodule
